// File: src/tach_pkg.sv
// shared types and constants of the multi-channel tachometer
`default_nettype none
package tach_pkg;

    // field widths
    localparam int RPM_W     = 26;
    localparam int TIME_W    = 32;
    localparam int COUNT_W   = 8;
    localparam int MOTOR_W   = 2;

    // rpm numerator: sixty million microseconds per minute
    localparam logic [RPM_W-1:0] RPM_NUMERATOR = 26'd60000000;

    // iterative divider: one quotient bit per cycle
    localparam int DIV_STEPS = RPM_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    // register reset values
    localparam logic [COUNT_W-1:0] PPR_RESET     = 8'd1;
    localparam logic [TIME_W-1:0]  TIMEOUT_RESET = 32'd1000000;

    // register indexes (word address bit)
    localparam logic REG_PPR     = 1'b0;
    localparam logic REG_TIMEOUT = 1'b1;

    // function codes of an input beat
    localparam logic FUNC_EDGE  = 1'b0;
    localparam logic FUNC_CHECK = 1'b1;

    typedef struct packed {
        logic                func;
        logic [MOTOR_W-1:0]  channel;
        logic [TIME_W-1:0]   time_us;
    } t_in_item;

    typedef struct packed {
        logic [MOTOR_W-1:0]  motor;
        logic [RPM_W-1:0]    speed_rpm;
        logic                stale;
        logic                last;
    } t_out_item;

    // controller to datapath
    typedef struct packed {
        logic latch;     // capture the accepted input beat
        logic edge_upd;  // count one edge on the latched channel
        logic rpm_wr;    // store the divider quotient
        logic chk_emit;  // check one channel and load its report
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic div_need;  // edge completed a revolution with nonzero elapsed time
        logic div_busy;
        logic div_done;
        logic out_free;  // output register can take a report this cycle
        logic chk_last;  // channel under check is the final one
    } t_status;

endpackage
`default_nettype wire

// File: src/tach_cfg.sv
// configuration registers behind an apb-style port
`default_nettype none
module tach_cfg (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [2:0]                  paddr,
    input  wire logic [31:0]                 pwdata,
    output logic      [31:0]                 prdata,
    output logic                             pready,
    output logic      [tach_pkg::COUNT_W-1:0] o_ppr,
    output logic      [tach_pkg::TIME_W-1:0]  o_timeout
);
    import tach_pkg::*;

    logic [COUNT_W-1:0] r_ppr;
    logic [TIME_W-1:0]  r_timeout;
    logic               wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ppr     <= PPR_RESET;
            r_timeout <= TIMEOUT_RESET;
        end else if (wr_en) begin
            case (paddr[2])
                REG_PPR:     r_ppr     <= pwdata[COUNT_W-1:0];
                REG_TIMEOUT: r_timeout <= pwdata;
                default:     r_ppr     <= r_ppr;
            endcase
        end
    end

    // read mux
    always_comb begin
        case (paddr[2])
            REG_PPR:     prdata = {{(32-COUNT_W){1'b0}}, r_ppr};
            REG_TIMEOUT: prdata = r_timeout;
            default:     prdata = '0;
        endcase
    end

    assign o_ppr     = r_ppr;
    assign o_timeout = r_timeout;

endmodule
`default_nettype wire

// File: src/tach_div.sv
// restoring divider: rpm numerator over elapsed microseconds, one bit a cycle
`default_nettype none
module tach_div (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [tach_pkg::TIME_W-1:0] i_divisor,
    output logic                             o_busy,
    output logic                             o_done,
    output logic      [tach_pkg::RPM_W-1:0]  o_quot
);
    import tach_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [TIME_W-1:0]    r_divisor;
    logic [TIME_W-1:0]    r_rem;
    logic [RPM_W-1:0]     r_num;
    logic [RPM_W-1:0]     r_quot;

    logic [TIME_W:0]      rem_sh;
    logic [TIME_W:0]      rem_sub;
    logic                 ge;

    // one trial subtraction
    always_comb begin
        rem_sh  = {r_rem, r_num[RPM_W-1]};
        rem_sub = rem_sh - {1'b0, r_divisor};
        ge      = (rem_sh >= {1'b0, r_divisor});
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(DIV_STEPS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_divisor <= i_divisor;
            r_rem     <= '0;
            r_num     <= RPM_NUMERATOR;
            r_quot    <= '0;
        end else if (r_busy) begin
            r_rem  <= ge ? rem_sub[TIME_W-1:0] : rem_sh[TIME_W-1:0];
            r_num  <= {r_num[RPM_W-2:0], 1'b0};
            r_quot <= {r_quot[RPM_W-2:0], ge};
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule
`default_nettype wire

// File: src/tach_dp.sv
// channel state, edge and timeout arithmetic, divider and output register
`default_nettype none
module tach_dp #(
    parameter int NUM_CHANNELS = 4
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire tach_pkg::t_cmd               i_cmd,
    output tach_pkg::t_status                 o_status,
    input  wire tach_pkg::t_in_item           i_in,
    input  wire logic [tach_pkg::COUNT_W-1:0] i_ppr,
    input  wire logic [tach_pkg::TIME_W-1:0]  i_timeout,
    output logic                              o_out_valid,
    input  wire logic                         i_out_stall,
    output tach_pkg::t_out_item               o_out
);
    import tach_pkg::*;

    localparam int CW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    // per-channel state
    logic [TIME_W-1:0]  r_start   [NUM_CHANNELS];
    logic [COUNT_W-1:0] r_count   [NUM_CHANNELS];
    logic [RPM_W-1:0]   r_rpm     [NUM_CHANNELS];
    logic               r_timed   [NUM_CHANNELS];

    // latched input beat and check index
    logic [MOTOR_W-1:0] r_chan;
    logic [TIME_W-1:0]  r_time;
    logic [CW-1:0]      r_idx;

    logic               r_out_valid;
    t_out_item          r_out;

    logic [CW-1:0]      ch_idx;
    logic               ch_ok;
    logic [TIME_W-1:0]  e_start;
    logic [COUNT_W-1:0] e_count;
    logic               e_done;
    logic [TIME_W-1:0]  e_elapsed;
    logic               e_zero;
    logic [TIME_W-1:0]  c_elapsed;
    logic               c_expire;
    logic               out_free;
    logic               div_start;
    logic               div_busy;
    logic               div_done;
    logic [RPM_W-1:0]   div_quot;

    // edge arithmetic on the latched channel
    always_comb begin
        ch_idx    = CW'(r_chan);
        ch_ok     = (32'(r_chan) < NUM_CHANNELS);
        e_start   = r_timed[ch_idx] ? r_time : r_start[ch_idx];
        e_count   = r_count[ch_idx] + 1'b1;
        e_done    = (e_count == i_ppr);
        e_elapsed = r_time - e_start;
        e_zero    = (e_elapsed == '0);
        div_start = i_cmd.edge_upd && ch_ok && e_done && !e_zero;
    end

    // timeout test on the channel under check
    always_comb begin
        c_elapsed = r_time - r_start[r_idx];
        c_expire  = (c_elapsed > i_timeout);
        out_free  = !r_out_valid || !i_out_stall;
    end

    tach_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (div_start),
        .i_divisor (e_elapsed),
        .o_busy    (div_busy),
        .o_done    (div_done),
        .o_quot    (div_quot)
    );

    // input latch and check index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (i_cmd.latch) begin
            r_idx <= '0;
        end else if (i_cmd.chk_emit) begin
            r_idx <= r_idx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_chan <= i_in.channel;
            r_time <= i_in.time_us;
        end
    end

    // channel state updates
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                r_start[i] <= '0;
                r_count[i] <= '0;
                r_rpm[i]   <= '0;
                r_timed[i] <= 1'b1;
            end
        end else if (i_cmd.edge_upd && ch_ok) begin
            r_timed[ch_idx] <= 1'b0;
            if (e_done) begin
                r_start[ch_idx] <= r_time;
                r_count[ch_idx] <= '0;
                if (e_zero) begin
                    r_rpm[ch_idx] <= RPM_NUMERATOR;
                end
            end else begin
                r_start[ch_idx] <= e_start;
                r_count[ch_idx] <= e_count;
            end
        end else if (i_cmd.rpm_wr) begin
            r_rpm[ch_idx] <= div_quot;
        end else if (i_cmd.chk_emit && c_expire) begin
            r_timed[r_idx] <= 1'b1;
            r_count[r_idx] <= '0;
            r_rpm[r_idx]   <= '0;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.chk_emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.chk_emit) begin
            r_out.motor     <= MOTOR_W'(r_idx);
            r_out.speed_rpm <= c_expire ? '0 : r_rpm[r_idx];
            r_out.stale     <= c_expire || r_timed[r_idx];
            r_out.last      <= (r_idx == CW'(NUM_CHANNELS - 1));
        end
    end

    // status back to the controller
    always_comb begin
        o_status.div_need = div_start;
        o_status.div_busy = div_busy;
        o_status.div_done = div_done;
        o_status.out_free = out_free;
        o_status.chk_last = (r_idx == CW'(NUM_CHANNELS - 1));
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule
`default_nettype wire

// File: src/tach_ctrl.sv
// controller state machine: sequences edges, divisions and check reports
`default_nettype none
module tach_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    input  wire logic               i_in_func,
    output logic                    o_in_stall,
    output tach_pkg::t_cmd          o_cmd,
    input  wire tach_pkg::t_status  i_status
);
    import tach_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EDGE,
        S_DIV,
        S_CHECK
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign o_in_stall = (r_state != S_IDLE);
    assign accept     = i_in_valid && (r_state == S_IDLE);

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.latch = 1'b1;
                    n_state = (i_in_func == FUNC_CHECK) ? S_CHECK : S_EDGE;
                end
            end
            S_EDGE: begin
                o_cmd.edge_upd = 1'b1;
                n_state = i_status.div_need ? S_DIV : S_IDLE;
            end
            S_DIV: begin
                if (i_status.div_done) begin
                    o_cmd.rpm_wr = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_CHECK: begin
                if (i_status.out_free) begin
                    o_cmd.chk_emit = 1'b1;
                    if (i_status.chk_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

`ifndef SYNTHESIS
    // divider is running or just finished while waiting for it
    a_div_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DIV |-> (i_status.div_busy || i_status.div_done))
        else $error("waiting for a divider that is not running");

    // a finished division is only seen while waiting for it
    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_status.div_done |-> r_state == S_DIV)
        else $error("divider finished outside the divide state");

    // an accepted beat always starts work
    a_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_state != S_IDLE)
        else $error("accepted beat left the controller idle");

    // final channel report ends the check
    a_chk_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.chk_emit && i_status.chk_last) |=> r_state == S_IDLE)
        else $error("check did not end after the final channel");
`endif

endmodule
`default_nettype wire

// File: src/multi_channel_tachometer.sv
// top level of the multi-channel tachometer
`default_nettype none
// Multi-channel pulse-period tachometer. Input beats are either a rising edge
// on one channel or a timeout check; only checks produce output, one report
// per channel in channel order, with last set on the final one. The block
// works on one input beat at a time. An edge is latched and then applied to its
// channel; one that finishes a revolution with nonzero elapsed time then waits
// for the bit-serial rpm divider before its rpm is stored. A check emits the
// reports in turn and waits while the output side stalls. The report
// sits in an output register, so a new beat is accepted while the final report
// of a check still waits. Registers: pulses_per_rev at byte address 0,
// timeout_us at byte address 4; write them only while the block is idle.
module multi_channel_tachometer #(
    parameter int NUM_CHANNELS = 4
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire tach_pkg::t_in_item   i_in,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output tach_pkg::t_out_item       o_out,
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [2:0]           paddr,
    input  wire logic [31:0]          pwdata,
    output logic      [31:0]          prdata,
    output logic                      pready
);
    import tach_pkg::*;

    t_cmd               cmd;
    t_status            status;
    logic [COUNT_W-1:0] ppr;
    logic [TIME_W-1:0]  timeout;

    // configuration registers
    tach_cfg u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .o_ppr     (ppr),
        .o_timeout (timeout)
    );

    // controller
    tach_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_func  (i_in.func),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd),
        .i_status   (status)
    );

    // datapath
    tach_dp #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_in        (i_in),
        .i_ppr       (ppr),
        .i_timeout   (timeout),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

endmodule
`default_nettype wire
